FILE: sv/blp_pkg.sv
package blp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  localparam logic REG_MAX_POINTS = 1'b0;
  localparam logic [6:0] MAX_POINTS_RST = 7'd64;

  typedef struct packed {
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] point_x;
    logic [7:0] point_y;
    logic [5:0] point_index;
    logic       last_point;
  } result_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic emit;
    logic busy;
  } ctrl_t;

endpackage

FILE: sv/bresenham_line_path.sv
// After start is taken the item is captured, a setup state follows, and then
// the run emits one point per cycle. An item of N points holds busy through setup
// and run, sharing one error adder; N <= max_points, clamped to 1..MAX_PATH.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (async, active low) returns to idle and sets max_points to 64.
module bresenham_line_path #(
  parameter int COORD_BITS = 8,
  parameter int MAX_PATH   = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  blp_pkg::in_item_t in_item_i,
  output logic              result_valid_o,
  output blp_pkg::result_t  result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import blp_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int EW    = COORD_BITS + 4;
  localparam int CNT_W = $clog2(MAX_PATH + 1);

  ctrl_t ctrl;

  logic [6:0]       max_points_q;
  logic [CB-1:0]    sx_q, sy_q, ex_q, ey_q;
  logic [CB-1:0]    x_q, y_q;
  logic             negx_q, negy_q, col_q;
  logic [DW-1:0]    d2maj_q, d2min_q;
  logic [EW-1:0]    err_q;
  logic [CNT_W-1:0] idx_q;

  logic [CB:0]      dx, dy;
  logic [CB-1:0]    adx, ady;
  logic             col_c;
  logic [DW-1:0]    d2maj, d2min;
  logic [EW-1:0]    err_nx;
  logic             step;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] idx_inc;
  logic             last;
  logic [CB-1:0]    x_step, y_step;

  // register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_POINTS) prdata = 32'(max_points_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_points_q <= MAX_POINTS_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_POINTS) begin
      max_points_q <= pwdata[6:0];
    end
  end

  always_comb begin
    if (max_points_q == 7'd0) begin
      limit = CNT_W'(1);
    end else if (max_points_q > 7'(MAX_PATH)) begin
      limit = CNT_W'(MAX_PATH);
    end else begin
      limit = CNT_W'(max_points_q);
    end
  end

  // setup arithmetic
  assign dx    = {1'b0, ex_q} - {1'b0, sx_q};
  assign dy    = {1'b0, ey_q} - {1'b0, sy_q};
  assign adx   = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady   = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  assign col_c = adx > ady;

  assign d2maj = ctrl.setup ? (col_c ? {adx, 1'b0} : {ady, 1'b0}) : d2maj_q;
  assign d2min = ctrl.setup ? (col_c ? {ady, 1'b0} : {adx, 1'b0}) : d2min_q;

  blp_err_unit #(
    .DW(DW),
    .EW(EW)
  ) u_err (
    .setup_i (ctrl.setup),
    .err_i   (err_q),
    .d2maj_i (d2maj),
    .d2min_i (d2min),
    .err_o   (err_nx),
    .step_o  (step)
  );

  assign idx_inc = CNT_W'(idx_q + 1'b1);
  assign last    = (idx_inc == limit) || (col_q ? (x_q == ex_q) : (y_q == ey_q));
  assign x_step  = negx_q ? CB'(x_q - 1'b1) : CB'(x_q + 1'b1);
  assign y_step  = negy_q ? CB'(y_q - 1'b1) : CB'(y_q + 1'b1);

  blp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .last_i  (last),
    .ctrl_o  (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.capture) begin
      sx_q <= CB'(in_item_i.start_x);
      sy_q <= CB'(in_item_i.start_y);
      ex_q <= CB'(in_item_i.end_x);
      ey_q <= CB'(in_item_i.end_y);
    end
    if (ctrl.setup) begin
      x_q     <= sx_q;
      y_q     <= sy_q;
      negx_q  <= dx[CB];
      negy_q  <= dy[CB];
      col_q   <= col_c;
      d2maj_q <= d2maj;
      d2min_q <= d2min;
      err_q   <= err_nx;
      idx_q   <= '0;
    end
    if (ctrl.emit) begin
      err_q <= err_nx;
      idx_q <= idx_inc;
      if (col_q) begin
        x_q <= x_step;
        if (step) y_q <= y_step;
      end else begin
        y_q <= y_step;
        if (step) x_q <= x_step;
      end
    end
  end

  assign busy                 = ctrl.busy;
  assign result_valid_o       = ctrl.emit;
  assign result_o.point_x     = 8'(x_q);
  assign result_o.point_y     = 8'(y_q);
  assign result_o.point_index = 6'(idx_q);
  assign result_o.last_point  = last;

endmodule

FILE: sv/blp_err_unit.sv
module blp_err_unit #(
  parameter int DW = 9,
  parameter int EW = 12
) (
  input  logic          setup_i,
  input  logic [EW-1:0] err_i,
  input  logic [DW-1:0] d2maj_i,
  input  logic [DW-1:0] d2min_i,
  output logic [EW-1:0] err_o,
  output logic          step_o
);
  logic [EW-1:0] base;
  logic [EW-1:0] sub;
  logic [EW-1:0] maj_ext;
  logic [EW-1:0] min_ext;

  // setup: d2min + d2min - d2maj gives the initial error
  assign maj_ext = EW'(d2maj_i);
  assign min_ext = EW'(d2min_i);
  assign step_o  = ~err_i[EW-1];
  assign base    = setup_i ? min_ext : err_i;
  assign sub     = (setup_i || step_o) ? maj_ext : '0;
  assign err_o   = base + min_ext - sub;

endmodule

FILE: sv/blp_ctrl.sv
module blp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          last_i,
  output blp_pkg::ctrl_t ctrl_o
);
  import blp_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (last_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.capture = start_i;
      end
      ST_SETUP: begin
        ctrl_o.setup = 1'b1;
        ctrl_o.busy  = 1'b1;
      end
      ST_RUN: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.busy = 1'b1;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

FILE: sv/blp_checker.sv
module blp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input logic             result_valid_i,
  input blp_pkg::result_t result_i,
  input logic             pready_i
);
  import blp_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("busy not raised after an item was taken");

  a_first_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |-> ##2 (result_valid_i && result_i.point_index == 6'd0))
    else $error("first point missing or not at index zero");

  a_run_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !result_i.last_point |=>
      result_valid_i && result_i.point_index == $past(result_i.point_index) + 6'd1)
    else $error("path broken before its last point");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && result_i.last_point |=> !result_valid_i && !busy_i)
    else $error("output continued after last point");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |-> busy_i && pready_i)
    else $error("result strobed while idle");

endmodule

bind bresenham_line_path blp_checker u_blp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .result_valid_i (result_valid_o),
  .result_i       (result_o),
  .pready_i       (pready)
);
